### rtl/ubds_pkg.sv
// Package of shared constants, codes and control types for the baud divisor search unit.
`timescale 1ns / 1ps
package ubds_pkg;

  localparam int unsigned MAX_SCALE_CODE = 9;
  localparam int unsigned DIVISOR_MAX    = 255;

  localparam int unsigned RATE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DIV_W    = 8;

  localparam int unsigned OS_LOG2_MAX = 4;
  localparam int unsigned MIN_DEN     = 16 * DIVISOR_MAX;
  localparam int unsigned MIN_DEN_W   = $clog2(MIN_DEN + 1);
  localparam int unsigned THR_W       = RATE_W + 1 + MIN_DEN_W;
  localparam int unsigned QUO_W       = RATE_W;
  localparam int unsigned DEN_W       = RATE_W + OS_LOG2_MAX;

  localparam logic [RATE_W-1:0] SYS_CLK_RESET = RATE_W'(96000000);

  localparam logic [DIV_W-1:0] DIV_LIMIT   = 8'hFF;
  localparam logic [DIV_W-1:0] DIV_CLAMP_H = 8'hFE;
  localparam logic [DIV_W-1:0] DIV_CLAMP_L = 8'h01;

  localparam logic [MODE_W-1:0] MODE_X4 = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_HIGH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    OP_QUOT  = 2'd0,
    OP_RATE0 = 2'd1,
    OP_RATE1 = 2'd2
  } div_op_e;

  typedef struct packed {
    logic                load;
    logic                scale_step;
    logic                div_start;
    div_op_e             div_op;
    logic                latch_quot;
    logic                dec_shift;
    logic                clamp;
    logic                latch_err0;
    logic                latch_sel;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } ubds_cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic scale_lt;
    logic scale_last;
    logic div_done;
    logic quot_zero;
    logic quot_big;
    logic shift_zero;
    logic out_busy;
  } ubds_sts_t;

endpackage

### rtl/ubds_in_if.sv
// Input channel interface carrying one requested bit rate per beat.
`timescale 1ns / 1ps
interface ubds_in_if import ubds_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] target_rate;

  modport source (output valid, output target_rate, input ready);
  modport sink (input valid, input target_rate, output ready);
endinterface

### rtl/ubds_out_if.sv
// Output channel interface carrying one divisor search result per beat.
`timescale 1ns / 1ps
interface ubds_out_if import ubds_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SCALE_W-1:0]  clock_scale;
  logic [MODE_W-1:0]   oversample_mode;
  logic [DIV_W-1:0]    divisor;

  modport source (output valid, output status, output clock_scale, output oversample_mode,
                  output divisor, input ready);
  modport sink (input valid, input status, input clock_scale, input oversample_mode,
                input divisor, output ready);
endinterface

### rtl/uart_baud_divisor_search_unit.sv
// Top level of the UART baud divisor search unit.
// Unless the target is zero or unreachable, a search runs up to 9 prescale steps, then
// one to five divisions on one shared divider.
// Throughput: one beat at a time; the next beat is taken while a result still waits.
// Reset clears the controller and the output valid and loads the clock register
// with 96 MHz.
`timescale 1ns / 1ps
module uart_baud_divisor_search_unit import ubds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  ubds_in_if.sink           in_i,
  ubds_out_if.source        out_o
);

  ubds_cmd_t cmd;
  ubds_sts_t sts;

  ubds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ubds_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .target_rate_i     (in_i.target_rate),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .status_o          (out_o.status),
    .clock_scale_o     (out_o.clock_scale),
    .oversample_mode_o (out_o.oversample_mode),
    .divisor_o         (out_o.divisor)
  );

endmodule

### rtl/ubds_divider.sv
// Restoring radix-2 divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module ubds_divider import ubds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QUO_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, quo_q[QUO_W-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

### rtl/ubds_datapath.sv
// Datapath holding the clock register, scale search, shared divider and result register.
`timescale 1ns / 1ps
module ubds_datapath import ubds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RATE_W-1:0]   cfg_wdata_i,
  input  logic [RATE_W-1:0]   target_rate_i,
  input  ubds_cmd_t           cmd_i,
  output ubds_sts_t           sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SCALE_W-1:0]  clock_scale_o,
  output logic [MODE_W-1:0]   oversample_mode_o,
  output logic [DIV_W-1:0]    divisor_o
);

  function automatic logic [RATE_W-1:0] abs_diff(input logic [RATE_W-1:0] a,
                                                 input logic [RATE_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [RATE_W-1:0]   sys_clk_q;
  logic [RATE_W-1:0]   target_q;
  logic [THR_W-1:0]    thresh_q;
  logic [SCALE_W-1:0]  code_q;
  logic [MODE_W-1:0]   shift_q;
  logic [RATE_W-1:0]   uclk_q;
  logic [QUO_W-1:0]    quot_q;
  logic [RATE_W-1:0]   err0_q;
  logic [DIV_W-1:0]    sel_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [SCALE_W-1:0]  res_scale_q;
  logic [MODE_W-1:0]   res_mode_q;
  logic [DIV_W-1:0]    res_div_q;

  logic [RATE_W-1:0] shifted;
  logic [2:0]        lsh;
  logic [DEN_W-1:0]  den;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;
  logic [RATE_W-1:0] err1;
  logic [DIV_W-1:0]  div8;

  assign shifted = sys_clk_q >> code_q;
  assign lsh     = 3'(OS_LOG2_MAX) - {1'b0, shift_q};
  assign div8    = quot_q[DIV_W-1:0];
  assign err1    = abs_diff(target_q, div_quo);

  always_comb begin
    case (cmd_i.div_op)
      OP_RATE0: den = DEN_W'(div8) << lsh;
      OP_RATE1: den = DEN_W'({1'b0, div8} + 9'd1) << lsh;
      default:  den = DEN_W'(target_q) << lsh;
    endcase
  end

  ubds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (uclk_q),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sts_o.tgt_zero   = target_q == '0;
    sts_o.scale_lt   = THR_W'(shifted) >= thresh_q;
    sts_o.scale_last = code_q >= SCALE_W'(MAX_SCALE_CODE - 1);
    sts_o.div_done   = div_done;
    sts_o.quot_zero  = quot_q == '0;
    sts_o.quot_big   = quot_q > QUO_W'(DIV_LIMIT);
    sts_o.shift_zero = shift_q == '0;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_clk_q   <= SYS_CLK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sys_clk_q <= cfg_wdata_i;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= target_rate_i;
      thresh_q <= THR_W'(THR_W'({1'b0, target_rate_i} + 33'd1) * THR_W'(MIN_DEN));
      code_q   <= '0;
      shift_q  <= MODE_X4;
    end
    if (cmd_i.scale_step) begin
      code_q <= code_q + SCALE_W'(1);
      uclk_q <= shifted;
    end
    if (cmd_i.dec_shift) begin
      shift_q <= shift_q - MODE_W'(1);
    end
    if (cmd_i.latch_quot) begin
      quot_q <= div_quo;
    end else if (cmd_i.clamp) begin
      if (div8 == DIV_LIMIT) begin
        quot_q <= QUO_W'(DIV_CLAMP_H);
      end else if (div8 == '0) begin
        quot_q <= QUO_W'(DIV_CLAMP_L);
      end
    end
    if (cmd_i.latch_err0) begin
      err0_q <= abs_diff(target_q, div_quo);
    end
    if (cmd_i.latch_sel) begin
      sel_q <= (err0_q < err1) ? div8 : div8 + DIV_W'(1);
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      unique case (cmd_i.res_status) inside
        ST_OK: begin
          res_scale_q <= code_q;
          res_mode_q  <= shift_q;
          res_div_q   <= sel_q;
        end
        ST_TOO_HIGH, ST_OVERFLOW: begin
          res_scale_q <= code_q;
          res_mode_q  <= '0;
          res_div_q   <= '0;
        end
        default: begin
          res_scale_q <= '0;
          res_mode_q  <= '0;
          res_div_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_status_q;
  assign clock_scale_o     = res_scale_q;
  assign oversample_mode_o = res_mode_q;
  assign divisor_o         = res_div_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");
  a_low_no_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_status_q == ST_TOO_LOW |-> res_scale_q == '0)
    else $error("too-low result carries a scale code");
  a_ok_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_status_q == ST_OK |-> res_div_q != '0 && res_scale_q != '0)
    else $error("successful result with zero divisor or scale");

endmodule

### rtl/ubds_ctrl.sv
// Controller state machine sequencing the scale search and the divisions.
`timescale 1ns / 1ps
module ubds_ctrl import ubds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ubds_sts_t sts_i,
  output ubds_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_QCHK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]          state_q, state_d;
  div_op_e             phase_q, phase_d;
  logic [STATUS_W-1:0] fin_q, fin_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fin_d      = fin_q;
    cmd_o      = '0;
    cmd_o.div_op     = phase_q;
    cmd_o.res_status = fin_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCALE;
        end
      end
      S_SCALE: begin
        if (sts_i.tgt_zero) begin
          fin_d   = ST_TOO_LOW;
          state_d = S_FIN;
        end else begin
          cmd_o.scale_step = 1'b1;
          if (!sts_i.scale_lt) begin
            phase_d = OP_QUOT;
            state_d = S_DIV;
          end else if (sts_i.scale_last) begin
            fin_d   = ST_TOO_LOW;
            state_d = S_FIN;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          unique case (phase_q)
            OP_RATE0: begin
              cmd_o.latch_err0 = 1'b1;
              phase_d          = OP_RATE1;
              state_d          = S_DIV;
            end
            OP_RATE1: begin
              cmd_o.latch_sel = 1'b1;
              fin_d           = ST_OK;
              state_d         = S_FIN;
            end
            default: begin
              cmd_o.latch_quot = 1'b1;
              state_d          = S_QCHK;
            end
          endcase
        end
      end
      S_QCHK: begin
        if (sts_i.quot_zero) begin
          fin_d   = ST_TOO_HIGH;
          state_d = S_FIN;
        end else if (sts_i.quot_big) begin
          if (sts_i.shift_zero) begin
            fin_d   = ST_OVERFLOW;
            state_d = S_FIN;
          end else begin
            cmd_o.dec_shift = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.clamp = 1'b1;
          phase_d     = OP_RATE0;
          state_d     = S_DIV;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= OP_QUOT;
      fin_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fin_q   <= fin_d;
    end
  end

endmodule
